// ===== rtl/sqlx_pkg.sv =====
// ----------------------------------------------------------------------------
// sqlx_pkg
// Shared types, token kinds, character codes and the keyword table of the
// SQL query lexer.
// ----------------------------------------------------------------------------
package sqlx_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int RES_DEPTH         = 4;
    localparam int KW_COUNT          = 18;
    localparam int KW_MAX_LEN        = 6;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_WORD,
        MODE_QUOTE,
        MODE_DONE
    } t_mode;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_DOUBLE,
        Q_SINGLE,
        Q_BTICK
    } t_quote;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start_res;
        logic [15:0] length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_op;

    localparam logic [5:0] KIND_SEMI    = 6'd0;
    localparam logic [5:0] KIND_NUMERIC = 6'd16;
    localparam logic [5:0] KIND_STRING  = 6'd17;
    localparam logic [5:0] KIND_IDENT   = 6'd18;
    localparam logic [5:0] KIND_KW0     = 6'd19;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_BTICK    = 8'h60;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_Z    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Keyword text, first character in the low byte.
    localparam logic [KW_COUNT-1:0][47:0] KW_TEXT = '{
        48'h0000_0000_3E3E,   // >>
        48'h0000_0000_3C3C,   // <<
        48'h0000_0044_4F4D,   // MOD
        48'h0000_0056_4944,   // DIV
        48'h0000_0000_524F,   // OR
        48'h0000_0044_4E41,   // AND
        48'h0000_0000_5942,   // BY
        48'h0052_4544_524F,   // ORDER
        48'h0050_554F_5247,   // GROUP
        48'h0045_5245_4857,   // WHERE
        48'h0000_4D4F_5246,   // FROM
        48'h5443_454C_4553,   // SELECT
        48'h0045_534C_4146,   // FALSE
        48'h0000_4555_5254,   // TRUE
        48'h0000_0054_4F4E,   // NOT
        48'h0000_4353_4544,   // DESC
        48'h0000_0043_5341,   // ASC
        48'h0000_0000_5341    // AS
    };

    localparam logic [KW_COUNT-1:0][2:0] KW_LEN = '{
        3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd5, 3'd5,
        3'd5, 3'd4, 3'd6, 3'd5, 3'd4, 3'd3, 3'd4, 3'd3, 3'd2
    };

    function automatic t_op op_lookup(input logic [7:0] c);
        t_op r;
        r.hit = 1'b1;
        case (c)
            8'h3B: r.idx = 4'd0;
            8'h2C: r.idx = 4'd1;
            8'h2E: r.idx = 4'd2;
            8'h28: r.idx = 4'd3;
            8'h29: r.idx = 4'd4;
            8'h3D: r.idx = 4'd5;
            8'h2B: r.idx = 4'd6;
            8'h2D: r.idx = 4'd7;
            8'h2A: r.idx = 4'd8;
            8'h21: r.idx = 4'd9;
            8'h2F: r.idx = 4'd10;
            8'h5E: r.idx = 4'd11;
            8'h7E: r.idx = 4'd12;
            8'h25: r.idx = 4'd13;
            8'h26: r.idx = 4'd14;
            8'h7C: r.idx = 4'd15;
            default: begin
                r.hit = 1'b0;
                r.idx = 4'd0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sqlx_scan.sv =====
// ----------------------------------------------------------------------------
// sqlx_scan
// Scanner state and per-byte token logic: one byte per cycle while i_take is
// high, up to two results per byte.
// ----------------------------------------------------------------------------
module sqlx_scan #(
    parameter int POSITION_BITS = sqlx_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = sqlx_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic [7:0]               i_byte_req,
    input  logic                     i_last_byte,
    input  logic                     i_case_fold,
    output sqlx_pkg::t_result [1:0]  o_res,
    output logic [1:0]               o_res_cnt
);
    import sqlx_pkg::*;

    localparam int IW = $clog2(KEYWORD_CHARS);

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [KEYWORD_CHARS-1:0][7:0] t_pfx;

    localparam t_pos POS_MAX = '1;

    t_mode   r_mode, n_mode, m_mode;
    t_quote  r_quote, n_quote, m_quote;
    logic    r_esc, n_esc, m_esc;
    t_pos    r_pos, n_pos, m_pos;
    t_pos    r_start, n_start, m_start;
    t_pos    r_len, n_len, m_len;
    t_pfx    r_pfx, n_pfx, m_pfx;

    t_op        op;
    logic [7:0] c;
    logic [7:0] qc;
    logic       is_digit;
    logic       idle_pass;
    logic       a_vld;
    logic       s_vld;
    t_result    a_res;
    t_result    s_res;

    function automatic t_pos sat_inc(input t_pos v);
        return (v == POS_MAX) ? v : v + t_pos'(1);
    endfunction

    function automatic logic [5:0] word_kind(input t_pfx pfx, input t_pos len,
                                             input logic fold);
        logic [5:0] kind;
        logic       same;
        logic [7:0] ch;
        kind = KIND_IDENT;
        if (len <= t_pos'(KEYWORD_CHARS)) begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                same = (len == t_pos'(KW_LEN[k]));
                for (int i = 0; i < KW_MAX_LEN; i++) begin
                    ch = pfx[i];
                    if (fold && ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
                        ch = ch - CASE_OFFSET;
                    end
                    if (i < int'(KW_LEN[k]) && ch != KW_TEXT[k][8*i +: 8]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    kind = KIND_KW0 + 6'(k);
                end
            end
        end
        return kind;
    endfunction

    function automatic t_result make_res(input logic [5:0] kind, input t_pos start,
                                         input t_pos len);
        t_result r;
        r.kind      = kind;
        r.start_res = 16'(start);
        r.length    = 16'(len);
        r.last      = 1'b0;
        return r;
    endfunction

    always_comb begin
        c        = i_byte_req;
        op       = op_lookup(c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

        case (r_quote)
            Q_DOUBLE: qc = CH_DQUOTE;
            Q_SINGLE: qc = CH_SQUOTE;
            default:  qc = CH_BTICK;
        endcase

        m_mode    = r_mode;
        m_quote   = r_quote;
        m_esc     = r_esc;
        m_start   = r_start;
        m_len     = r_len;
        m_pfx     = r_pfx;
        idle_pass = 1'b0;
        a_vld     = 1'b0;
        a_res     = make_res(KIND_IDENT, r_start, r_len);

        case (r_mode)
            MODE_QUOTE: begin
                if (c == qc && !r_esc) begin
                    a_vld   = 1'b1;
                    a_res   = make_res((r_quote == Q_BTICK) ? KIND_IDENT : KIND_STRING,
                                       r_start, r_len);
                    m_mode  = MODE_IDLE;
                    m_quote = Q_NONE;
                end else begin
                    m_esc = (c == CH_BSLASH) ? ~r_esc : 1'b0;
                    m_len = sat_inc(r_len);
                end
            end
            MODE_NUM: begin
                if (is_digit || c == CH_DOT) begin
                    m_len = sat_inc(r_len);
                end else begin
                    a_vld     = 1'b1;
                    a_res     = make_res(KIND_NUMERIC, r_start, r_len);
                    m_mode    = MODE_IDLE;
                    m_quote   = Q_NONE;
                    m_esc     = 1'b0;
                    idle_pass = 1'b1;
                end
            end
            MODE_WORD: begin
                if (c == CH_SPACE || op.hit) begin
                    a_vld     = 1'b1;
                    a_res     = make_res(word_kind(r_pfx, r_len, i_case_fold),
                                         r_start, r_len);
                    m_mode    = MODE_IDLE;
                    m_quote   = Q_NONE;
                    m_esc     = 1'b0;
                    idle_pass = 1'b1;
                end else begin
                    if (r_len < t_pos'(KEYWORD_CHARS)) begin
                        m_pfx[r_len[IW-1:0]] = c;
                    end
                    m_len = sat_inc(r_len);
                end
            end
            MODE_IDLE: begin
                idle_pass = 1'b1;
            end
            default: begin
            end
        endcase

        s_vld = 1'b0;
        s_res = make_res(KIND_IDENT, r_pos, r_len);

        if (idle_pass) begin
            if (c == CH_SPACE) begin
                m_mode = MODE_IDLE;
            end else if (op.hit) begin
                s_vld  = 1'b1;
                s_res  = make_res(6'(op.idx), r_pos, t_pos'(1));
                m_mode = (6'(op.idx) == KIND_SEMI) ? MODE_DONE : MODE_IDLE;
            end else if (is_digit) begin
                m_mode  = MODE_NUM;
                m_start = r_pos;
                m_len   = t_pos'(1);
            end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BTICK) begin
                m_mode  = MODE_QUOTE;
                m_start = sat_inc(r_pos);
                m_len   = '0;
                m_esc   = 1'b0;
                m_quote = (c == CH_DQUOTE) ? Q_DOUBLE :
                          (c == CH_SQUOTE) ? Q_SINGLE : Q_BTICK;
            end else begin
                m_mode   = MODE_WORD;
                m_start  = r_pos;
                m_pfx[0] = c;
                m_len    = t_pos'(1);
            end
        end

        m_pos = sat_inc(r_pos);

        n_mode  = m_mode;
        n_quote = m_quote;
        n_esc   = m_esc;
        n_pos   = m_pos;
        n_start = m_start;
        n_len   = m_len;
        n_pfx   = m_pfx;

        if (i_last_byte) begin
            case (m_mode)
                MODE_NUM: begin
                    s_vld = 1'b1;
                    s_res = make_res(KIND_NUMERIC, m_start, m_len);
                end
                MODE_WORD: begin
                    s_vld = 1'b1;
                    s_res = make_res(word_kind(m_pfx, m_len, i_case_fold),
                                     m_start, m_len);
                end
                MODE_QUOTE: begin
                    s_vld = 1'b1;
                    s_res = make_res((m_quote == Q_BTICK) ? KIND_IDENT : KIND_STRING,
                                     m_start, m_len);
                end
                default: begin
                end
            endcase
            n_mode  = MODE_IDLE;
            n_quote = Q_NONE;
            n_esc   = 1'b0;
            n_pos   = '0;
            n_start = '0;
            n_len   = '0;
        end

        o_res = '0;
        if (a_vld) begin
            o_res[0]      = a_res;
            o_res[1]      = s_res;
            o_res[0].last = ~s_vld;
            o_res[1].last = 1'b1;
        end else begin
            o_res[0]      = s_res;
            o_res[0].last = 1'b1;
        end
        o_res_cnt = i_take ? ({1'b0, a_vld} + {1'b0, s_vld}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_quote <= Q_NONE;
            r_esc   <= 1'b0;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_esc   <= n_esc;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pfx <= n_pfx;
        end
    end

endmodule

// ===== rtl/sqlx_rq.sv =====
// ----------------------------------------------------------------------------
// sqlx_rq
// Result queue: takes up to two results per cycle, hands out one per
// transfer on the valid/stall output channel.
// ----------------------------------------------------------------------------
module sqlx_rq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sqlx_pkg::t_result [1:0]  i_push,
    input  logic [1:0]               i_push_cnt,
    input  logic                     i_pop,
    output logic                     o_valid,
    output logic                     o_full,
    output sqlx_pkg::t_result        o_head
);
    import sqlx_pkg::*;

    localparam int AW = $clog2(RES_DEPTH);
    localparam int CW = $clog2(RES_DEPTH + 1);

    t_result         r_mem [RES_DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            pop_ok;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count > CW'(RES_DEPTH - 2));
    assign o_head  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr + AW'(i_push_cnt);
        n_rd    = r_rd + AW'(pop_ok);
        n_count = r_count + CW'(i_push_cnt) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push[0];
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_push[1];
        end
    end

endmodule

// ===== rtl/sql_query_lexer_top.sv =====
// ----------------------------------------------------------------------------
// sql_query_lexer_top
// Streaming SQL tokenizer: one query byte in, tokens out as kind, start
// offset and length.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while o_stall is low. Each byte is scanned in the
// cycle it transfers and its zero, one or two tokens go into a four-entry
// result queue, which drains one token per output transfer. Input stall
// rises while fewer than two queue entries are free. With the output never
// stalled the block sustains one byte per cycle; each token is registered in
// the result queue and the tokens of a byte leave its head in order. The
// case-fold register resets to 1 and is written through the cfg channel,
// which is always ready.
module sql_query_lexer_top #(
    parameter int POSITION_BITS = sqlx_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = sqlx_pkg::KEYWORD_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_req,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_kind,
    output logic [15:0] o_start_res,
    output logic [15:0] o_length,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_keyword_case_fold
);
    import sqlx_pkg::*;

    logic             r_case_fold;
    logic             take;
    logic             full;
    t_result [1:0]    res;
    logic [1:0]       res_cnt;
    t_result          head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign take        = i_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_fold <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_case_fold <= i_keyword_case_fold;
        end
    end

    sqlx_scan #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte_req  (i_byte_req),
        .i_last_byte (i_last_byte),
        .i_case_fold (r_case_fold),
        .o_res       (res),
        .o_res_cnt   (res_cnt)
    );

    sqlx_rq u_rq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res),
        .i_push_cnt (res_cnt),
        .i_pop      (!i_stall),
        .o_valid    (o_valid),
        .o_full     (full),
        .o_head     (head)
    );

    assign o_kind      = head.kind;
    assign o_start_res = head.start_res;
    assign o_length    = head.length;
    assign o_last      = head.last;

endmodule
